>>> hw/rtl/cwag_pkg.sv
// Shared types and constants of the convolution window address generator.
`default_nettype none

package cwag_pkg;

   localparam int unsigned COORD_W  = 10;
   localparam int unsigned TAP_W    = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 11;

   localparam logic [3:0]  KERNEL_MAX = 4'd8;
   localparam logic [10:0] DIM_MAX    = 11'd1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAD_ROW     = 3'd0,
      CSR_PAD_COL     = 3'd1,
      CSR_STRIDE_ROW  = 3'd2,
      CSR_STRIDE_COL  = 3'd3,
      CSR_KERNEL_ROWS = 3'd4,
      CSR_KERNEL_COLS = 3'd5,
      CSR_IMAGE_ROWS  = 3'd6,
      CSR_IMAGE_COLS  = 3'd7
   } csr_index_type;

   // Configuration after saturation of kernel and image sizes.
   typedef struct packed {
      logic [2:0]  pad_row;
      logic [2:0]  pad_col;
      logic [3:0]  stride_row;
      logic [3:0]  stride_col;
      logic [3:0]  kernel_rows;
      logic [3:0]  kernel_cols;
      logic [10:0] image_rows;
      logic [10:0] image_cols;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic origin;
      logic range;
      logic walk_start;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic range_empty;
      logic out_free;
      logic at_last;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ORIGIN = 4'b0010,
      ST_RANGE  = 4'b0100,
      ST_WALK   = 4'b1000
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/cwag_csr.sv
// Configuration registers with kernel and image size saturation.
`default_nettype none

module cwag_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [cwag_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cwag_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output cwag_pkg::cfg_type                     cfg
);
   import cwag_pkg::*;

   logic [2:0]  pad_row_ff, pad_col_ff;
   logic [3:0]  stride_row_ff, stride_col_ff;
   logic [3:0]  kernel_rows_ff, kernel_cols_ff;
   logic [10:0] image_rows_ff, image_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_row_ff     <= 3'd0;
         pad_col_ff     <= 3'd0;
         stride_row_ff  <= 4'd1;
         stride_col_ff  <= 4'd1;
         kernel_rows_ff <= 4'd3;
         kernel_cols_ff <= 4'd3;
         image_rows_ff  <= 11'd1024;
         image_cols_ff  <= 11'd1024;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PAD_ROW:     pad_row_ff     <= csr_wdata[2:0];
            CSR_PAD_COL:     pad_col_ff     <= csr_wdata[2:0];
            CSR_STRIDE_ROW:  stride_row_ff  <= csr_wdata[3:0];
            CSR_STRIDE_COL:  stride_col_ff  <= csr_wdata[3:0];
            CSR_KERNEL_ROWS: kernel_rows_ff <= csr_wdata[3:0];
            CSR_KERNEL_COLS: kernel_cols_ff <= csr_wdata[3:0];
            CSR_IMAGE_ROWS:  image_rows_ff  <= csr_wdata[10:0];
            CSR_IMAGE_COLS:  image_cols_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.pad_row     = pad_row_ff;
      cfg.pad_col     = pad_col_ff;
      cfg.stride_row  = stride_row_ff;
      cfg.stride_col  = stride_col_ff;
      cfg.kernel_rows = (kernel_rows_ff > KERNEL_MAX) ? KERNEL_MAX : kernel_rows_ff;
      cfg.kernel_cols = (kernel_cols_ff > KERNEL_MAX) ? KERNEL_MAX : kernel_cols_ff;
      cfg.image_rows  = (image_rows_ff > DIM_MAX) ? DIM_MAX : image_rows_ff;
      cfg.image_cols  = (image_cols_ff > DIM_MAX) ? DIM_MAX : image_cols_ff;
   end

endmodule

`default_nettype wire

>>> hw/rtl/cwag_datapath.sv
// Window origin, valid tap range and tap walk with the result register.
`default_nettype none

module cwag_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cwag_pkg::cfg_type               cfg,
   input  wire cwag_pkg::cmd_type               cmd,
   output cwag_pkg::status_type                 status,
   input  wire logic [cwag_pkg::COORD_W-1:0]    out_row,
   input  wire logic [cwag_pkg::COORD_W-1:0]    out_col,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [cwag_pkg::COORD_W-1:0]         rsp_in_col,
   output logic [cwag_pkg::COORD_W-1:0]         rsp_in_row,
   output logic [cwag_pkg::TAP_W-1:0]           rsp_tap_col,
   output logic [cwag_pkg::TAP_W-1:0]           rsp_tap_row,
   output logic                                 rsp_last
);
   import cwag_pkg::*;

   logic [COORD_W-1:0] row_ff, col_ff;
   logic [13:0]        prod_row, prod_col;
   logic signed [15:0] orow_ff, ocol_ff, orow_in, ocol_in;

   logic signed [16:0] orow_x, ocol_x;
   logic signed [16:0] row_lo, row_hi_k, row_hi_i, row_hi;
   logic signed [16:0] col_lo, col_hi_k, col_hi_i, col_hi;
   logic               empty;

   logic [TAP_W-1:0]   m_hi_ff, n_lo_ff, n_hi_ff;
   logic [TAP_W-1:0]   m_ff, n_ff, m_in, n_in;
   logic signed [16:0] r_full, c_full;
   logic               at_last;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] in_col_ff, in_row_ff;
   logic [TAP_W-1:0]   tap_col_ff, tap_row_ff;
   logic               last_ff;

   // origin = position * stride - pad
   assign prod_row = 14'(row_ff) * 14'(cfg.stride_row);
   assign prod_col = 14'(col_ff) * 14'(cfg.stride_col);
   assign orow_in  = $signed({2'b00, prod_row}) - $signed({13'd0, cfg.pad_row});
   assign ocol_in  = $signed({2'b00, prod_col}) - $signed({13'd0, cfg.pad_col});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff <= out_row;
         col_ff <= out_col;
      end
      if (cmd.origin) begin
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
      end
   end

   // valid taps form one contiguous block: lo = max(0,-o), hi = min(k-1, size-1-o)
   always_comb begin
      orow_x   = {orow_ff[15], orow_ff};
      ocol_x   = {ocol_ff[15], ocol_ff};
      row_lo   = (orow_x < 0) ? -orow_x : 17'sd0;
      col_lo   = (ocol_x < 0) ? -ocol_x : 17'sd0;
      row_hi_k = $signed({13'd0, cfg.kernel_rows}) - 17'sd1;
      col_hi_k = $signed({13'd0, cfg.kernel_cols}) - 17'sd1;
      row_hi_i = $signed({6'd0, cfg.image_rows}) - 17'sd1 - orow_x;
      col_hi_i = $signed({6'd0, cfg.image_cols}) - 17'sd1 - ocol_x;
      row_hi   = (row_hi_k < row_hi_i) ? row_hi_k : row_hi_i;
      col_hi   = (col_hi_k < col_hi_i) ? col_hi_k : col_hi_i;
      empty    = (row_hi < row_lo) || (col_hi < col_lo);
   end

   always_ff @(posedge clock) begin
      if (cmd.range) begin
         m_hi_ff <= row_hi[TAP_W-1:0];
         n_lo_ff <= col_lo[TAP_W-1:0];
         n_hi_ff <= col_hi[TAP_W-1:0];
      end
   end

   assign at_last = (m_ff == m_hi_ff) && (n_ff == n_hi_ff);

   // advance along the row, wrap to the next kernel row
   always_comb begin
      m_in = m_ff;
      n_in = n_ff;
      if (cmd.walk_start) begin
         m_in = row_lo[TAP_W-1:0];
         n_in = col_lo[TAP_W-1:0];
      end else if (cmd.step) begin
         if (n_ff == n_hi_ff) begin
            n_in = n_lo_ff;
            m_in = m_ff + TAP_W'(1);
         end else begin
            n_in = n_ff + TAP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      n_ff <= n_in;
   end

   assign r_full = orow_x + $signed({14'd0, m_ff});
   assign c_full = ocol_x + $signed({14'd0, n_ff});

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         in_col_ff  <= c_full[COORD_W-1:0];
         in_row_ff  <= r_full[COORD_W-1:0];
         tap_col_ff <= n_ff;
         tap_row_ff <= m_ff;
         last_ff    <= at_last;
      end
   end

   assign status = '{range_empty: empty,
                     out_free:    !rsp_valid_ff || rsp_ready,
                     at_last:     at_last};

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_in_col  = in_col_ff;
   assign rsp_in_row  = in_row_ff;
   assign rsp_tap_col = tap_col_ff;
   assign rsp_tap_row = tap_row_ff;
   assign rsp_last    = last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/cwag_controller.sv
// Sequencer for one window: capture, origin, range, tap walk.
`default_nettype none

module cwag_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire cwag_pkg::status_type status,
   output cwag_pkg::cmd_type         cmd
);
   import cwag_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ORIGIN;
            end
         end
         ST_ORIGIN: begin
            cmd.origin = 1'b1;
            state_in   = ST_RANGE;
         end
         ST_RANGE: begin
            cmd.range = 1'b1;
            // drop a window that has no tap inside the image
            if (status.range_empty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.walk_start = 1'b1;
               state_in       = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.at_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/conv_window_address_generator_core.sv
// Top level of the convolution window address generator.
//
// Usage: each req beat carries one output position (out_row, out_col) of a
// strided, padded convolution or pooling layer. The block expands it into the
// input taps of its window, kernel row by kernel row, and sends one rsp beat
// per tap that falls inside the image; tlast marks the final tap of a window.
// A window lying wholly in padding sends no beat at all.
// Configuration must be written through the csr port only while the block is
// idle; the block itself does not enforce this. The first tap passes the origin
// and range states and the tap walk before it enters the result register. The
// tap walk counter steps one tap per cycle while the receiver takes beats, and
// the req side waits until the walk ends.
// Reset clears the sequencer and the rsp valid flag and loads the default
// configuration (no padding, unit strides, 3x3 kernel, 1024x1024 image).
// When the receiver stalls, the result register holds its beat and the walk
// pauses; a new req beat is taken as soon as the last tap sits in the register.
`default_nettype none

module conv_window_address_generator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // out_row[9:0], out_col[19:10], zero [23:20]
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // in_col[9:0], in_row[19:10], tap_col[22:20], tap_row[25:23], zero [31:26]
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);
   import cwag_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   logic [COORD_W-1:0] in_col, in_row;
   logic [TAP_W-1:0]   tap_col, tap_row;

   cwag_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cwag_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   cwag_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .out_row     (req_tdata[9:0]),
      .out_col     (req_tdata[19:10]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_in_col  (in_col),
      .rsp_in_row  (in_row),
      .rsp_tap_col (tap_col),
      .rsp_tap_row (tap_row),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, tap_row, tap_col, in_row, in_col};

endmodule

`default_nettype wire

>>> dv/conv_window_address_generator_core_tb.sv
// Stream testbench of the convolution window address generator: predicted tap beats vs. rsp.
module conv_window_address_generator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cwag_pkg::*;

   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AFTER   = 40;

   typedef struct packed {
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
   } position_type;

   typedef struct packed {
      logic [COORD_W-1:0] in_col;
      logic [COORD_W-1:0] in_row;
      logic [TAP_W-1:0]   tap_col;
      logic [TAP_W-1:0]   tap_row;
      logic               last;
   } tap_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [23:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;
   logic          rsp_tlast;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_PAD_ROW;
   logic [10:0]   csr_wdata = '0;

   // register image as the block holds it after reset
   cfg_type   shadow = '{pad_row: 3'd0, pad_col: 3'd0, stride_row: 4'd1, stride_col: 4'd1,
                         kernel_rows: 4'd3, kernel_cols: 4'd3,
                         image_rows: 11'd1024, image_cols: 11'd1024};

   position_type pending_positions[$];
   tap_type      taps_due[$];
   int        positions_taken = 0;
   int        quiet_cycles = 0;
   int        failures = 0;
   bit        calm = 1'b0;

   conv_window_address_generator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Walk the kernel rows, then columns, and queue every tap inside the image.
   task automatic expand_window(input logic [COORD_W-1:0] out_row,
                                input logic [COORD_W-1:0] out_col);
      int      row0, col0, krows, kcols, irows, icols, r, c;
      tap_type found[$];
      tap_type t;
      row0  = int'(out_row) * int'(shadow.stride_row) - int'(shadow.pad_row);
      col0  = int'(out_col) * int'(shadow.stride_col) - int'(shadow.pad_col);
      krows = (shadow.kernel_rows > KERNEL_MAX) ? int'(KERNEL_MAX) : int'(shadow.kernel_rows);
      kcols = (shadow.kernel_cols > KERNEL_MAX) ? int'(KERNEL_MAX) : int'(shadow.kernel_cols);
      irows = (shadow.image_rows > DIM_MAX) ? int'(DIM_MAX) : int'(shadow.image_rows);
      icols = (shadow.image_cols > DIM_MAX) ? int'(DIM_MAX) : int'(shadow.image_cols);
      for (int m = 0; m < krows; m++) begin
         r = row0 + m;
         if (r < 0 || r >= irows) continue;
         for (int n = 0; n < kcols; n++) begin
            c = col0 + n;
            if (c < 0 || c >= icols) continue;
            t.in_col  = c[COORD_W-1:0];
            t.in_row  = r[COORD_W-1:0];
            t.tap_col = n[TAP_W-1:0];
            t.tap_row = m[TAP_W-1:0];
            t.last    = 1'b0;
            found.push_back(t);
         end
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) taps_due.push_back(found[i]);
   endtask

   task automatic report_miss(input string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // sender: one beat per handshake, random gaps between beats
   int gap_left = 0;
   position_type next_pos;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_positions.size() > 0) begin
            next_pos = pending_positions.pop_front();
            req_tdata  <= {4'b0, next_pos.out_col, next_pos.out_row};
            req_tvalid <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 9);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold to back the block up
   int  stall_left = 0;
   int  run_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && positions_taken >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (run_left > 0) begin
         run_left--;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         rsp_tready <= 1'b0;
      end else begin
         run_left = $urandom_range(1, 30);
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on req beats, check rsp beats in order
   tap_type seen, want;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expand_window(req_tdata[9:0], req_tdata[19:10]);
            positions_taken <= positions_taken + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = '{in_col: rsp_tdata[9:0], in_row: rsp_tdata[19:10],
                     tap_col: rsp_tdata[22:20], tap_row: rsp_tdata[25:23],
                     last: rsp_tlast};
            if (taps_due.size() == 0) begin
               report_miss($sformatf("unexpected tap col=%0d row=%0d kc=%0d kr=%0d last=%0b",
                                     seen.in_col, seen.in_row, seen.tap_col, seen.tap_row,
                                     seen.last));
            end else begin
               want = taps_due.pop_front();
               if (seen.in_col !== want.in_col || seen.in_row !== want.in_row ||
                   seen.tap_col !== want.tap_col || seen.tap_row !== want.tap_row ||
                   seen.last !== want.last)
                  report_miss($sformatf({"expected col=%0d row=%0d kc=%0d kr=%0d last=%0b, ",
                                         "got col=%0d row=%0d kc=%0d kr=%0d last=%0b"},
                                        want.in_col, want.in_row, want.tap_col, want.tap_row,
                                        want.last, seen.in_col, seen.in_row, seen.tap_col,
                                        seen.tap_row, seen.last));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_positions.size() > 0 || req_tvalid || taps_due.size() > 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [10:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PAD_ROW:     shadow.pad_row     = value[2:0];
         CSR_PAD_COL:     shadow.pad_col     = value[2:0];
         CSR_STRIDE_ROW:  shadow.stride_row  = value[3:0];
         CSR_STRIDE_COL:  shadow.stride_col  = value[3:0];
         CSR_KERNEL_ROWS: shadow.kernel_rows = value[3:0];
         CSR_KERNEL_COLS: shadow.kernel_cols = value[3:0];
         CSR_IMAGE_ROWS:  shadow.image_rows  = value;
         CSR_IMAGE_COLS:  shadow.image_cols  = value;
         default: ;
      endcase
   endtask

   // Write all registers; noise fills the bits above each narrow register.
   task automatic apply_config(input int p_row, input int p_col, input int s_row,
                               input int s_col, input int k_rows, input int k_cols,
                               input int i_rows, input int i_cols, input bit noisy);
      logic [10:0] noise;
      noise = noisy ? 11'($urandom) : 11'd0;
      write_reg(CSR_PAD_ROW,     {noise[10:3], 3'(p_row)});
      write_reg(CSR_PAD_COL,     {noise[10:3], 3'(p_col)});
      write_reg(CSR_STRIDE_ROW,  {noise[10:4], 4'(s_row)});
      write_reg(CSR_STRIDE_COL,  {noise[10:4], 4'(s_col)});
      write_reg(CSR_KERNEL_ROWS, {noise[10:4], 4'(k_rows)});
      write_reg(CSR_KERNEL_COLS, {noise[10:4], 4'(k_cols)});
      write_reg(CSR_IMAGE_ROWS,  11'(i_rows));
      write_reg(CSR_IMAGE_COLS,  11'(i_cols));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic offer(input int out_row, input int out_col);
      pending_positions.push_back('{out_row: 10'(out_row), out_col: 10'(out_col)});
   endtask

   function automatic int reach(input int pad, input int stride, input int img);
      int span;
      span = ((img > int'(DIM_MAX)) ? int'(DIM_MAX) : img) + pad;
      if (stride == 0 || span == 0) return 1023;
      return ((span - 1) / stride > 1023) ? 1023 : (span - 1) / stride;
   endfunction

   task automatic random_phase(input int count);
      int p_row, p_col, s_row, s_col, k_rows, k_cols, i_rows, i_cols, max_row, max_col;
      p_row  = $urandom_range(0, 7);
      p_col  = $urandom_range(0, 7);
      s_row  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      s_col  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      k_rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      k_cols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      i_rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 48);
      i_cols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 48);
      wait_drained();
      apply_config(p_row, p_col, s_row, s_col, k_rows, k_cols, i_rows, i_cols,
                   $urandom_range(0, 1));
      max_row = reach(p_row, s_row, i_rows);
      max_col = reach(p_col, s_col, i_cols);
      // mostly windows that overlap the image, the rest anywhere
      repeat (count) begin
         if ($urandom_range(0, 6) == 0)
            offer($urandom_range(0, 1023), $urandom_range(0, 1023));
         else
            offer($urandom_range(0, max_row), $urandom_range(0, max_col));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: image corners and a middle point
      offer(0, 0);
      offer(1023, 1023);
      offer(0, 1023);
      offer(1023, 0);
      offer(517, 300);

      // deep padding: windows wholly in padding, then partial and full ones
      wait_drained();
      apply_config(7, 7, 1, 1, 3, 3, 1024, 1024, 1'b0);
      offer(0, 0);
      offer(1, 1);
      offer(6, 9);
      offer(8, 8);

      // largest kernel and stride
      wait_drained();
      apply_config(0, 0, 15, 15, 8, 8, 1024, 1024, 1'b1);
      offer(0, 0);
      offer(68, 68);
      offer(1023, 1023);
      offer(68, 0);

      // zero kernel height
      wait_drained();
      apply_config(0, 0, 1, 1, 0, 3, 16, 16, 1'b0);
      offer(2, 2);

      // oversized kernel and image saturate
      wait_drained();
      apply_config(0, 0, 1, 1, 15, 15, 2047, 2047, 1'b0);
      offer(1020, 1020);
      offer(0, 512);

      // zero image height, then zero stride
      wait_drained();
      apply_config(3, 1, 0, 0, 4, 2, 0, 9, 1'b1);
      offer(5, 5);
      wait_drained();
      apply_config(3, 1, 0, 0, 4, 2, 9, 9, 1'b0);
      offer(0, 0);
      offer(1023, 1023);
      offer(512, 7);

      repeat (5) random_phase(16);
      wait_drained();
      calm = 1'b1;
      random_phase(16);

      wait_drained();
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
